FILE: hw/rtl/kmw_pkg.sv
package kmw_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 4096;
    localparam int WEIGHT_BITS   = 48;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

    // Fixed field widths
    localparam int COST_W     = 12;
    localparam int ITEM_WGT_W = 32;
    localparam int OUT_WGT_W  = 48;
    localparam int ACT_W      = 2;

    // Width that holds both a cost field and any table index without wrap
    localparam int CMP_W = ((ADDR_W > COST_W) ? ADDR_W : COST_W) + 1;
    // Width of the candidate weight sum before saturation
    localparam int SUM_W = ((WEIGHT_BITS > ITEM_WGT_W) ? WEIGHT_BITS : ITEM_WGT_W) + 1;

    // Largest finite weight: 2^WEIGHT_BITS - 2
    localparam logic [SUM_W-1:0] WEIGHT_LIMIT =
        {{(SUM_W-WEIGHT_BITS){1'b0}}, {(WEIGHT_BITS-1){1'b1}}, 1'b0};

    localparam logic [COST_W-1:0] MAX_COST_RESET = {COST_W{1'b1}};
    localparam logic [ADDR_W-1:0] LAST_ENTRY     = ADDR_W'(TABLE_ENTRIES - 1);

    // Action codes; the last one doubles as the error kind
    localparam logic [ACT_W-1:0] ACT_ADD   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
    localparam logic [ACT_W-1:0] ACT_BAD   = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]      action;
        logic [COST_W-1:0]     item_cost;
        logic [ITEM_WGT_W-1:0] item_weight;
        logic [COST_W-1:0]     read_index;
    } item_t;

    typedef struct packed {
        logic [OUT_WGT_W-1:0] entry_weight;
        logic                 reachable;
        logic [ACT_W-1:0]     done_kind;
    } result_t;

    typedef struct packed {
        logic                   reach;
        logic [WEIGHT_BITS-1:0] weight;
    } entry_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } wr_port_t;

endpackage

FILE: hw/rtl/kmw_table.sv
module kmw_table
(
    input  logic              clk,
    input  kmw_pkg::wr_port_t wr,
    input  logic [kmw_pkg::ADDR_W-1:0] rd_a_addr,
    input  logic [kmw_pkg::ADDR_W-1:0] rd_b_addr,
    output kmw_pkg::entry_t   rd_a_data,
    output kmw_pkg::entry_t   rd_b_data
);
    import kmw_pkg::*;

    entry_t mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

FILE: hw/rtl/kmw_engine.sv
module kmw_engine
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start_accept,
    input  kmw_pkg::item_t             item,
    input  logic [kmw_pkg::CMP_W-1:0]  top_idx,
    output logic                       busy,
    output logic                       done,
    output kmw_pkg::result_t           result,
    output kmw_pkg::wr_port_t          wr,
    output logic [kmw_pkg::ADDR_W-1:0] rd_a_addr,
    output logic [kmw_pkg::ADDR_W-1:0] rd_b_addr,
    input  kmw_pkg::entry_t            rd_a_data,
    input  kmw_pkg::entry_t            rd_b_data
);
    import kmw_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_NOP   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [ADDR_W-1:0]     cnt_reg, cnt_next;
    logic                  report_reg, report_next;
    logic                  p1_valid_reg, p1_valid_next;
    logic                  p2_valid_reg, p2_valid_next;

    logic [ADDR_W-1:0]     j_reg, j_next;
    logic [ADDR_W-1:0]     cost_reg, cost_next;
    logic [ITEM_WGT_W-1:0] wgt_reg, wgt_next;
    logic [ACT_W-1:0]      kind_reg, kind_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [ADDR_W-1:0]     p1_addr_reg;
    logic [ADDR_W-1:0]     p2_addr_reg;
    logic [WEIGHT_BITS-1:0] cand_reg, cand_next;
    logic [WEIGHT_BITS-1:0] old_w_reg;
    logic                  old_r_reg;
    logic                  src_r_reg;

    logic [CMP_W-1:0]      cost_cmp;
    logic                  add_ok;
    logic [SUM_W-1:0]      sum;
    logic                  take;

    assign cost_cmp = CMP_W'(item.item_cost);
    assign add_ok   = (cost_cmp != '0) && (cost_cmp <= top_idx);

    // Stage 1: saturating candidate from the predecessor entry
    assign sum       = SUM_W'(rd_b_data.weight) + SUM_W'(wgt_reg);
    assign cand_next = (sum > WEIGHT_LIMIT) ? WEIGHT_BITS'(WEIGHT_LIMIT) : WEIGHT_BITS'(sum);

    // Stage 2: keep the lighter of old and candidate
    assign take = p2_valid_reg && src_r_reg && (!old_r_reg || (cand_reg < old_w_reg));

    assign busy = (state_reg != ST_IDLE);

    assign rd_a_addr = (state_reg == ST_IDLE) ? ADDR_W'(item.read_index) : j_reg;
    assign rd_b_addr = j_reg - cost_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        report_next   = report_reg;
        p1_valid_next = 1'b0;
        p2_valid_next = p1_valid_reg;
        j_next        = j_reg;
        cost_next     = cost_reg;
        wgt_next      = wgt_reg;
        kind_next     = kind_reg;
        rd_ok_next    = rd_ok_reg;
        done          = 1'b0;
        result        = '0;
        result.done_kind = kind_reg;
        wr.we         = take;
        wr.addr       = p2_addr_reg;
        wr.data.reach  = 1'b1;
        wr.data.weight = cand_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_accept)
                begin
                    kind_next = item.action;
                    unique case (item.action)
                        ACT_ADD:
                        begin
                            j_next     = top_idx[ADDR_W-1:0];
                            cost_next  = cost_cmp[ADDR_W-1:0];
                            wgt_next   = item.item_weight;
                            state_next = add_ok ? ST_SWEEP : ST_NOP;
                        end
                        ACT_READ:
                        begin
                            rd_ok_next = (CMP_W'(item.read_index) <= top_idx);
                            state_next = ST_READ;
                        end
                        ACT_CLEAR:
                        begin
                            cnt_next    = '0;
                            report_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_NOP;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                // Write one entry a cycle; only entry 0 comes back reachable
                wr.we          = 1'b1;
                wr.addr        = cnt_reg;
                wr.data.reach  = (cnt_reg == '0);
                wr.data.weight = '0;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ENTRY)
                begin
                    done       = report_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                p1_valid_next = 1'b1;
                if (j_reg == cost_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                done = 1'b1;
                if (rd_ok_reg && rd_a_data.reach)
                begin
                    result.entry_weight = OUT_WGT_W'(rd_a_data.weight);
                    result.reachable    = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_NOP:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            report_reg   <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            report_reg   <= report_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg       <= j_next;
        cost_reg    <= cost_next;
        wgt_reg     <= wgt_next;
        kind_reg    <= kind_next;
        rd_ok_reg   <= rd_ok_next;
        p1_addr_reg <= j_reg;
        p2_addr_reg <= p1_addr_reg;
        cand_reg    <= cand_next;
        old_w_reg   <= rd_a_data.weight;
        old_r_reg   <= rd_a_data.reach;
        src_r_reg   <= rd_b_data.reach;
    end

`ifndef SYNTH
    // Every accepted item makes the engine busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start_accept && !busy |=> busy)
        else $error("engine not busy after accepting an item");

    // Finishing an item frees the engine
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("engine still busy after completion");

    // Predecessor read always below the entry being updated: no read-after-write overlap
    a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> rd_b_addr < rd_a_addr)
        else $error("sweep predecessor not below target entry");

    // Sweep updates never land below the item cost
    a_sweep_floor: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we && state_reg != ST_CLEAR |-> wr.addr >= cost_reg)
        else $error("sweep write below item cost");
`endif

endmodule

FILE: hw/rtl/knapsack_min_weight_by_cost_dp_core.sv
// 0/1 knapsack table engine: least weight for every total cost 0..max_cost.
//
// Command channel: present an item on `item` and raise start; the item
// transfers at a rising edge with start high and busy low. Actions: add item,
// read one entry, clear the table. Every item yields exactly one result.
// Result channel: `result` is valid for the single cycle in which done is
// high; the receiver cannot stall it, so sample it then.
// Configuration: cfg_data (max_cost) transfers when cfg_valid and cfg_ready
// are both high; cfg_ready is always high. Write only while idle.
//
// An add sweeps the entries from max_cost down to the item cost: one
// read-modify-write of one entry per cycle through a three-stage read /
// sum / compare-write pipe. A clear writes all 4096 entries.
// A new item can transfer in the cycle done is high.
// Reset: max_cost returns to 4095 and a clearing pass writes all 4096
// entries (busy high), leaving only entry 0 reachable.
module knapsack_min_weight_by_cost_dp_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  kmw_pkg::item_t             item,
    output logic                       done,
    output kmw_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [kmw_pkg::COST_W-1:0] cfg_data
);
    import kmw_pkg::*;

    logic [COST_W-1:0] max_cost_reg;
    logic [CMP_W-1:0]  top_idx;
    logic              start_accept;
    logic              eng_busy;
    logic              eng_done;
    result_t           eng_result;
    logic              done_reg;
    result_t           result_reg;
    wr_port_t          wr;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    entry_t            rd_a_data;
    entry_t            rd_b_data;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_cost_reg <= MAX_COST_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_cost_reg <= cfg_data;
        end
    end

    // Clamp the tracked range to the last table entry
    assign top_idx = (CMP_W'(max_cost_reg) >= CMP_W'(TABLE_ENTRIES))
                     ? CMP_W'(TABLE_ENTRIES - 1) : CMP_W'(max_cost_reg);

    assign busy         = eng_busy;
    assign start_accept = start && !eng_busy;

    kmw_engine u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_accept (start_accept),
        .item         (item),
        .top_idx      (top_idx),
        .busy         (eng_busy),
        .done         (eng_done),
        .result       (eng_result),
        .wr           (wr),
        .rd_a_addr    (rd_a_addr),
        .rd_b_addr    (rd_b_addr),
        .rd_a_data    (rd_a_data),
        .rd_b_data    (rd_b_data)
    );

    kmw_table u_table
    (
        .clk       (clk),
        .wr        (wr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    // Register the result: strobe for one cycle, hold payload until the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= eng_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            result_reg <= eng_result;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: dv/knapsack_min_weight_by_cost_dp_checker.sv
module knapsack_min_weight_by_cost_dp_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  kmw_pkg::item_t             item,
    input  logic                       done,
    input  kmw_pkg::result_t           result,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [kmw_pkg::COST_W-1:0] cfg_data,
    output int                         errors,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import kmw_pkg::*;

    // Shadow of the cost table: least weight and reachability per total cost
    logic [WEIGHT_BITS-1:0] least_wt [TABLE_ENTRIES];
    bit                     reached  [TABLE_ENTRIES];
    int                     cost_top;
    result_t                owed_reports [$];
    int                     mismatch_n;

    function automatic void wipe_table();
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            least_wt[i] = '0;
            reached[i]  = 1'b0;
        end
        reached[0] = 1'b1;
    endfunction

    function automatic int clip_top(input logic [COST_W-1:0] v);
        return (int'(v) >= TABLE_ENTRIES) ? TABLE_ENTRIES - 1 : int'(v);
    endfunction

    // Apply one command to the shadow table and return the report it owes
    function automatic result_t apply_command(input item_t cmd);
        result_t          r;
        int               c;
        logic [SUM_W-1:0] cand;
        r           = '0;
        r.done_kind = cmd.action;
        c           = int'(cmd.item_cost);
        case (cmd.action)
            ACT_ADD:
            begin
                // Sweep downward so each item is used at most once
                if (c != 0 && c <= cost_top)
                begin
                    for (int j = cost_top; j >= c; j--)
                    begin
                        if (reached[j - c])
                        begin
                            cand = SUM_W'(least_wt[j - c]) + SUM_W'(cmd.item_weight);
                            if (cand > WEIGHT_LIMIT)
                                cand = WEIGHT_LIMIT;
                            if (!reached[j] || cand[WEIGHT_BITS-1:0] < least_wt[j])
                            begin
                                least_wt[j] = cand[WEIGHT_BITS-1:0];
                                reached[j]  = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_READ:
            begin
                if (int'(cmd.read_index) <= cost_top && reached[cmd.read_index])
                begin
                    r.entry_weight = OUT_WGT_W'(least_wt[cmd.read_index]);
                    r.reachable    = 1'b1;
                end
            end
            ACT_CLEAR:
                wipe_table();
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void flag(input string msg);
        mismatch_n++;
        if (mismatch_n <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            wipe_table();
            cost_top = clip_top(MAX_COST_RESET);
            owed_reports.delete();
            mismatch_n = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // Retire the oldest report before queuing a new one
            if (done)
            begin
                if (owed_reports.size() == 0)
                    flag($sformatf("unexpected result: weight %0d reach %0b kind %0d",
                                   result.entry_weight, result.reachable, result.done_kind));
                else
                begin
                    want = owed_reports.pop_front();
                    if (result.entry_weight !== want.entry_weight ||
                        result.reachable    !== want.reachable    ||
                        result.done_kind    !== want.done_kind)
                        flag($sformatf({"mismatch: expected weight %0d reach %0b kind %0d,",
                                        " got weight %0d reach %0b kind %0d"},
                                       want.entry_weight, want.reachable, want.done_kind,
                                       result.entry_weight, result.reachable,
                                       result.done_kind));
                end
            end
            if (cfg_valid && cfg_ready)
                cost_top = clip_top(cfg_data);
            if (start && !busy)
                owed_reports.push_back(apply_command(item));
            errors  <= mismatch_n;
            pending <= owed_reports.size();
        end
    end

endmodule

FILE: dv/tb_knapsack_min_weight_by_cost_dp_core.sv
module tb_knapsack_min_weight_by_cost_dp_core;
    timeunit 1ns;
    timeprecision 1ps;
    import kmw_pkg::*;

    // Longest legal silence: a full-table add or clear, the clearing pass
    // after reset, and the longest sender gap, with margin.
    localparam int QUIET_LIMIT = 20000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    item_t               item      = '0;
    logic                cfg_valid = 1'b0;
    logic [COST_W-1:0]   cfg_data  = '0;
    logic                busy;
    logic                done;
    result_t             result;
    logic                cfg_ready;
    int                  errors;
    int                  pending;
    int                  quiet     = 0;
    int                  burst_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    knapsack_min_weight_by_cost_dp_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Checker sits beside the block: it predicts every report and compares
    knapsack_min_weight_by_cost_dp_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // Watchdog: count cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("knapsack_min_weight_by_cost_dp_core regression: fail");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic item_t make_command(input logic [ACT_W-1:0] act, input int cost,
                                           input logic [ITEM_WGT_W-1:0] wt, input int idx);
        item_t cmd;
        cmd.action      = act;
        cmd.item_cost   = COST_W'(cost);
        cmd.item_weight = wt;
        cmd.read_index  = COST_W'(idx);
        return cmd;
    endfunction

    // Present one command and hold it until it transfers. Commands go out in
    // bursts: keep start high across a burst, drop it for a random gap after, unless the gap drawn is zero.
    task automatic send_command(input item_t cmd);
        int gap;
        start <= 1'b1;
        item  <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            // Every fifth burst or so runs long with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Write max_cost only once the block is idle and every report is back
    task automatic write_max_cost(input logic [COST_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One phase of random traffic at a given max_cost. Keep costs and read
    // indexes mostly inside the tracked range so adds chain into each other,
    // and throw in full-range values, zero cost and extreme weights.
    task automatic random_phase(input int top, input int count);
        item_t cmd;
        int    pick;
        int    span;
        span = (top + 2 > TABLE_ENTRIES - 1) ? TABLE_ENTRIES - 1 : top + 2;
        write_max_cost(COST_W'(top));
        repeat (count)
        begin
            cmd.item_cost   = COST_W'($urandom_range(0, TABLE_ENTRIES - 1));
            cmd.item_weight = $urandom;
            cmd.read_index  = COST_W'($urandom_range(0, TABLE_ENTRIES - 1));
            pick = $urandom_range(0, 99);
            if (pick < 50)
                cmd.action = ACT_ADD;
            else if (pick < 84)
                cmd.action = ACT_READ;
            else if (pick < 89)
                cmd.action = ACT_CLEAR;
            else
                cmd.action = ACT_BAD;
            case ($urandom_range(0, 9))
                0: ;
                1: cmd.item_cost = '0;
                default: cmd.item_cost = COST_W'($urandom_range(1, span));
            endcase
            case ($urandom_range(0, 7))
                0, 1: ;
                2: cmd.item_weight = '1;
                3: cmd.item_weight = '0;
                default: cmd.item_weight = ITEM_WGT_W'($urandom_range(1, 500));
            endcase
            if ($urandom_range(0, 5) != 0)
                cmd.read_index = COST_W'($urandom_range(0, span));
            send_command(cmd);
        end
    endtask

    initial
    begin
        burst_left = $urandom_range(1, 8);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Fresh table at full size: only cost 0 reachable
        send_command(make_command(ACT_READ, 0, '0, 0));
        send_command(make_command(ACT_READ, 4095, '1, 4095));
        // Zero-cost add leaves the table alone
        send_command(make_command(ACT_ADD, 0, 5, 0));
        // Top cost with the heaviest weight touches only the last entry
        send_command(make_command(ACT_ADD, 4095, '1, 0));
        send_command(make_command(ACT_READ, 0, '0, 4095));
        // Undefined action with every field at its top
        send_command(make_command(ACT_BAD, 4095, '1, 4095));
        send_command(make_command(ACT_CLEAR, 0, '0, 0));
        send_command(make_command(ACT_READ, 0, '0, 4095));

        // Small table: cost above the range, then a few competing items
        write_max_cost(3);
        send_command(make_command(ACT_ADD, 4, 7, 0));
        send_command(make_command(ACT_ADD, 1, 10, 0));
        send_command(make_command(ACT_ADD, 2, 15, 0));
        send_command(make_command(ACT_ADD, 1, 3, 0));
        send_command(make_command(ACT_READ, 0, '0, 3));
        send_command(make_command(ACT_READ, 0, '0, 4));
        send_command(make_command(ACT_READ, 0, '0, 2));

        // Shrink the range: entry 3 hides and is left untouched by adds
        write_max_cost(2);
        send_command(make_command(ACT_ADD, 1, 1, 0));
        send_command(make_command(ACT_READ, 0, '0, 3));

        // Grow it back without a clear: the old entry 3 shows again
        write_max_cost(3);
        send_command(make_command(ACT_READ, 0, '0, 3));
        send_command(make_command(ACT_CLEAR, 0, '0, 0));

        // Single-entry table: no add can land anywhere
        write_max_cost(0);
        send_command(make_command(ACT_ADD, 1, 9, 0));
        send_command(make_command(ACT_ADD, 0, 9, 0));
        send_command(make_command(ACT_READ, 0, '0, 0));
        send_command(make_command(ACT_READ, 0, '0, 1));

        // Random traffic over several ranges, extremes included. Phases do not
        // clear on entry, so lowering and raising the range exposes stale entries.
        random_phase(0, 12);
        random_phase(4095, 8);
        random_phase(12, 16);
        random_phase(63, 16);
        random_phase(5, 12);
        random_phase(250, 16);
        random_phase(31, 16);
        random_phase($urandom_range(1, 40), 21);

        // Drain: wait for every report, then let the pipe settle
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("knapsack_min_weight_by_cost_dp_core regression: pass");
        else
            $display("knapsack_min_weight_by_cost_dp_core regression: fail");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/kmw_pkg.sv
hw/rtl/kmw_table.sv
hw/rtl/kmw_engine.sv
hw/rtl/knapsack_min_weight_by_cost_dp_core.sv
dv/knapsack_min_weight_by_cost_dp_checker.sv
dv/tb_knapsack_min_weight_by_cost_dp_core.sv
